### src/assert_macros.svh
// Assertion macros for the checker file of the gradient palette unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held
`define HGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define HGP_ASSERT_NEVER(lbl, cond, msg) \
  `HGP_ASSERT(lbl, !(cond), msg)

`endif

### src/hgp_pkg.sv
// Package of the HSV gradient palette unit: widths, register codes, reset values
// and the structs passed between the pipeline cells. No dependencies.
`timescale 1ns / 1ps

package hgp_pkg;

  // Palette size limit and field widths
  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned SPAN_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned PROD_W      = CH_W + SPAN_W;
  localparam int unsigned NUM_CH      = 3;

  // One quotient bit per divider cell
  localparam int unsigned DIV_STEPS   = CH_W;
  // Front stage, divider cells, output stage
  localparam int unsigned PIPE_DEPTH  = DIV_STEPS + 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_FG_HUE      = 3'd1,
    REG_FG_SAT      = 3'd2,
    REG_FG_VAL      = 3'd3,
    REG_BG_HUE      = 3'd4,
    REG_BG_SAT      = 3'd5,
    REG_BG_VAL      = 3'd6
  } cfg_reg_e;

  // Channel lanes
  localparam int unsigned CH_HUE = 0;
  localparam int unsigned CH_SAT = 1;
  localparam int unsigned CH_VAL = 2;

  // Hue shorter-way thresholds: +128 and -128
  localparam logic signed [CH_W:0] HUE_HALF_POS = (CH_W+1)'(1 << (CH_W - 1));
  localparam logic signed [CH_W:0] HUE_HALF_NEG = -HUE_HALF_POS;
  // Moving the hue by 256 toggles the sign bit of the 9-bit difference
  localparam logic [CH_W:0]        HUE_WRAP     = (CH_W+1)'(1 << CH_W);

  // Reset values
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(16);
  localparam logic [CH_W-1:0]  FG_HUE_RST      = '0;
  localparam logic [CH_W-1:0]  FG_SAT_RST      = '0;
  localparam logic [CH_W-1:0]  FG_VAL_RST      = '1;
  localparam logic [CH_W-1:0]  BG_HUE_RST      = '0;
  localparam logic [CH_W-1:0]  BG_SAT_RST      = '0;
  localparam logic [CH_W-1:0]  BG_VAL_RST      = '0;

  // Gradient end colours
  typedef struct packed {
    logic [CH_W-1:0] fg_hue;
    logic [CH_W-1:0] fg_sat;
    logic [CH_W-1:0] fg_val;
    logic [CH_W-1:0] bg_hue;
    logic [CH_W-1:0] bg_sat;
    logic [CH_W-1:0] bg_val;
  } colour_cfg_t;

  // One channel in flight through the divider chain
  typedef struct packed {
    logic              neg;  // sign of fg - bg
    logic [SPAN_W-1:0] rem;  // partial remainder
    logic [CH_W-1:0]   low;  // dividend bits not yet consumed
    logic [CH_W-1:0]   quo;  // quotient bits so far
  } div_lane_t;

  typedef div_lane_t [NUM_CH-1:0] div_vec_t;

endpackage

### src/hgp_in_if.sv
// Input channel of the gradient palette unit: valid/ready plus the palette index.
// Depends on hgp_pkg.
`timescale 1ns / 1ps

interface hgp_in_if;
  logic                       valid;
  logic                       ready;
  logic [hgp_pkg::IDX_W-1:0]  entry_index;

  modport source (output valid, output entry_index, input ready);
  modport sink   (input valid, input entry_index, output ready);
endinterface

### src/hgp_out_if.sv
// Output channel of the gradient palette unit: valid/ready plus the HSV colour.
// Depends on hgp_pkg.
`timescale 1ns / 1ps

interface hgp_out_if;
  logic                      valid;
  logic                      ready;
  logic [hgp_pkg::CH_W-1:0]  hue;
  logic [hgp_pkg::CH_W-1:0]  sat;
  logic [hgp_pkg::CH_W-1:0]  val;

  modport source (output valid, output hue, output sat, output val, input ready);
  modport sink   (input valid, input hue, input sat, input val, output ready);
endinterface

### src/hgp_front.sv
// Front stage: clamps the index, forms fg - bg per channel (hue the short way)
// and the product magnitude, then loads the first divider slot. Uses hgp_pkg.
`timescale 1ns / 1ps

module hgp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hgp_pkg::colour_cfg_t         cfg_i,
  input  logic [hgp_pkg::SPAN_W-1:0]   span_i,
  input  logic                         up_valid_i,
  input  logic [hgp_pkg::IDX_W-1:0]    up_index_i,
  output logic                         up_ready_o,
  output logic                         dn_valid_o,
  output hgp_pkg::div_vec_t            dn_data_o,
  input  logic                         dn_ready_i
);

  logic                         valid_q;
  hgp_pkg::div_vec_t            data_q;
  hgp_pkg::div_vec_t            data_d;
  logic [hgp_pkg::SPAN_W-1:0]   idx_c;
  logic [hgp_pkg::CH_W-1:0]     fg_c [hgp_pkg::NUM_CH];
  logic [hgp_pkg::CH_W-1:0]     bg_c [hgp_pkg::NUM_CH];
  logic signed [hgp_pkg::CH_W:0] diff_c [hgp_pkg::NUM_CH];
  logic [hgp_pkg::CH_W-1:0]     absd_c [hgp_pkg::NUM_CH];
  logic [hgp_pkg::PROD_W-1:0]   prod_c [hgp_pkg::NUM_CH];

  // Slot frees when empty or when the next cell takes its item
  assign up_ready_o = !valid_q || dn_ready_i;

  // Index clamp to the last entry
  always_comb begin
    if (hgp_pkg::IDX_W'(span_i) < up_index_i) begin
      idx_c = span_i;
    end else begin
      idx_c = hgp_pkg::SPAN_W'(up_index_i);
    end
  end

  always_comb begin
    fg_c[hgp_pkg::CH_HUE] = cfg_i.fg_hue;
    fg_c[hgp_pkg::CH_SAT] = cfg_i.fg_sat;
    fg_c[hgp_pkg::CH_VAL] = cfg_i.fg_val;
    bg_c[hgp_pkg::CH_HUE] = cfg_i.bg_hue;
    bg_c[hgp_pkg::CH_SAT] = cfg_i.bg_sat;
    bg_c[hgp_pkg::CH_VAL] = cfg_i.bg_val;
  end

  // Per-channel difference, magnitude and product
  always_comb begin
    for (int c = 0; c < hgp_pkg::NUM_CH; c++) begin
      diff_c[c] = $signed({1'b0, fg_c[c]}) - $signed({1'b0, bg_c[c]});
      // hue goes the shorter way: moving bg by 256 flips the sign bit
      if (c == hgp_pkg::CH_HUE) begin
        if (diff_c[c] >= hgp_pkg::HUE_HALF_POS || diff_c[c] <= hgp_pkg::HUE_HALF_NEG) begin
          diff_c[c] = $signed(diff_c[c] ^ hgp_pkg::HUE_WRAP);
        end
      end
      if (diff_c[c][hgp_pkg::CH_W]) begin
        absd_c[c] = hgp_pkg::CH_W'(-diff_c[c]);
      end else begin
        absd_c[c] = diff_c[c][hgp_pkg::CH_W-1:0];
      end
      prod_c[c] = hgp_pkg::PROD_W'(absd_c[c]) * hgp_pkg::PROD_W'(idx_c);
      data_d[c].neg = diff_c[c][hgp_pkg::CH_W];
      data_d[c].rem = prod_c[c][hgp_pkg::PROD_W-1 -: hgp_pkg::SPAN_W];
      data_d[c].low = prod_c[c][hgp_pkg::CH_W-1:0];
      data_d[c].quo = '0;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

### src/hgp_div_cell.sv
// One cell of the divider chain: works out one quotient bit for every channel
// and hands the item on to its neighbour. Uses hgp_pkg.
`timescale 1ns / 1ps

module hgp_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hgp_pkg::SPAN_W-1:0]   divisor_i,
  input  logic                         up_valid_i,
  input  hgp_pkg::div_vec_t            up_data_i,
  output logic                         up_ready_o,
  output logic                         dn_valid_o,
  output hgp_pkg::div_vec_t            dn_data_o,
  input  logic                         dn_ready_i
);

  logic                         valid_q;
  hgp_pkg::div_vec_t            data_q;
  hgp_pkg::div_vec_t            data_d;
  logic [hgp_pkg::SPAN_W:0]     trial_c [hgp_pkg::NUM_CH];
  logic                         qbit_c  [hgp_pkg::NUM_CH];

  assign up_ready_o = !valid_q || dn_ready_i;

  // Restoring step: bring down the next bit, subtract if it fits
  always_comb begin
    for (int c = 0; c < hgp_pkg::NUM_CH; c++) begin
      trial_c[c] = {up_data_i[c].rem, up_data_i[c].low[hgp_pkg::CH_W-1]};
      qbit_c[c]  = (trial_c[c] >= {1'b0, divisor_i});
      data_d[c].neg = up_data_i[c].neg;
      if (qbit_c[c]) begin
        data_d[c].rem = hgp_pkg::SPAN_W'(trial_c[c] - {1'b0, divisor_i});
      end else begin
        data_d[c].rem = trial_c[c][hgp_pkg::SPAN_W-1:0];
      end
      data_d[c].low = {up_data_i[c].low[hgp_pkg::CH_W-2:0], 1'b0};
      data_d[c].quo = {up_data_i[c].quo[hgp_pkg::CH_W-2:0], qbit_c[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

### src/hgp_tail.sv
// Output stage: applies the sign to each quotient, adds the background value
// and holds the colour for the receiver. Uses hgp_pkg and hgp_out_if.
`timescale 1ns / 1ps

module hgp_tail (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hgp_pkg::colour_cfg_t  cfg_i,
  input  logic                  up_valid_i,
  input  hgp_pkg::div_vec_t     up_data_i,
  output logic                  up_ready_o,
  hgp_out_if.source             out_ch
);

  logic                      valid_q;
  logic [hgp_pkg::CH_W-1:0]  res_q [hgp_pkg::NUM_CH];
  logic [hgp_pkg::CH_W-1:0]  res_d [hgp_pkg::NUM_CH];
  logic [hgp_pkg::CH_W-1:0]  bg_c  [hgp_pkg::NUM_CH];

  assign up_ready_o = !valid_q || out_ch.ready;

  always_comb begin
    bg_c[hgp_pkg::CH_HUE] = cfg_i.bg_hue;
    bg_c[hgp_pkg::CH_SAT] = cfg_i.bg_sat;
    bg_c[hgp_pkg::CH_VAL] = cfg_i.bg_val;
  end

  // Quotient truncated toward zero, then wrapped sum with the background
  always_comb begin
    for (int c = 0; c < hgp_pkg::NUM_CH; c++) begin
      if (up_data_i[c].neg) begin
        res_d[c] = bg_c[c] - up_data_i[c].quo;
      end else begin
        res_d[c] = bg_c[c] + up_data_i[c].quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid = valid_q;
  assign out_ch.hue   = res_q[hgp_pkg::CH_HUE];
  assign out_ch.sat   = res_q[hgp_pkg::CH_SAT];
  assign out_ch.val   = res_q[hgp_pkg::CH_VAL];

endmodule

### src/hsv_gradient_palette_entry_unit.sv
// HSV gradient palette entry unit.
//
// Takes a palette index on in_ch and returns on out_ch the HSV colour of that
// entry on a straight gradient from the background colour (entry 0) to the
// foreground colour (last entry). Hue runs the shorter way round the circle.
// Both channels are valid/ready: an item moves on a rising edge with both high.
// Users set the end colours and entry_count through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i) only with no item in flight; the block never checks.
//
// An item accepted on in_ch passes through one front stage (clamp and
// multiply), eight divider cells (one quotient bit each) and the output
// register, and is then shown on out_ch. Throughput is one item per cycle
// while out_ch is not stalled; every cell of the chain is a full stage.
//
// When the receiver stalls the result is held and the chain keeps closing up
// behind it, so up to ten items are held before in_ch.ready drops.
// Reset empties the chain and loads the defaults: 16 entries, black to white.
`timescale 1ns / 1ps

module hsv_gradient_palette_entry_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hgp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hgp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  hgp_in_if.sink                            in_ch,
  hgp_out_if.source                         out_ch
);

  logic [hgp_pkg::CNT_W-1:0]   count_q;
  hgp_pkg::colour_cfg_t        colour_q;
  logic [hgp_pkg::SPAN_W-1:0]  span_c;
  logic [hgp_pkg::SPAN_W-1:0]  divisor_c;

  logic               stage_valid [hgp_pkg::DIV_STEPS+1];
  logic               stage_ready [hgp_pkg::DIV_STEPS+1];
  hgp_pkg::div_vec_t  stage_data  [hgp_pkg::DIV_STEPS+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= hgp_pkg::ENTRY_COUNT_RST;
      colour_q.fg_hue <= hgp_pkg::FG_HUE_RST;
      colour_q.fg_sat <= hgp_pkg::FG_SAT_RST;
      colour_q.fg_val <= hgp_pkg::FG_VAL_RST;
      colour_q.bg_hue <= hgp_pkg::BG_HUE_RST;
      colour_q.bg_sat <= hgp_pkg::BG_SAT_RST;
      colour_q.bg_val <= hgp_pkg::BG_VAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hgp_pkg::REG_ENTRY_COUNT: count_q <= cfg_data_i[hgp_pkg::CNT_W-1:0];
        hgp_pkg::REG_FG_HUE: colour_q.fg_hue <= cfg_data_i[hgp_pkg::CH_W-1:0];
        hgp_pkg::REG_FG_SAT: colour_q.fg_sat <= cfg_data_i[hgp_pkg::CH_W-1:0];
        hgp_pkg::REG_FG_VAL: colour_q.fg_val <= cfg_data_i[hgp_pkg::CH_W-1:0];
        hgp_pkg::REG_BG_HUE: colour_q.bg_hue <= cfg_data_i[hgp_pkg::CH_W-1:0];
        hgp_pkg::REG_BG_SAT: colour_q.bg_sat <= cfg_data_i[hgp_pkg::CH_W-1:0];
        hgp_pkg::REG_BG_VAL: colour_q.bg_val <= cfg_data_i[hgp_pkg::CH_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Span = count - 1, with zero count taken as one and saturation at the limit
  always_comb begin
    if (count_q == '0) begin
      span_c = '0;
    end else if (count_q > hgp_pkg::CNT_W'(hgp_pkg::MAX_ENTRIES)) begin
      span_c = hgp_pkg::SPAN_W'(hgp_pkg::MAX_ENTRIES - 1);
    end else begin
      span_c = hgp_pkg::SPAN_W'(count_q - hgp_pkg::CNT_W'(1));
    end
  end

  // Single entry: index and product are zero, dividing by one keeps it zero
  assign divisor_c = (span_c == '0) ? hgp_pkg::SPAN_W'(1) : span_c;

  hgp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (colour_q),
    .span_i     (span_c),
    .up_valid_i (in_ch.valid),
    .up_index_i (in_ch.entry_index),
    .up_ready_o (in_ch.ready),
    .dn_valid_o (stage_valid[0]),
    .dn_data_o  (stage_data[0]),
    .dn_ready_i (stage_ready[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < hgp_pkg::DIV_STEPS; k++) begin : g_div
    hgp_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .divisor_i  (divisor_c),
      .up_valid_i (stage_valid[k]),
      .up_data_i  (stage_data[k]),
      .up_ready_o (stage_ready[k]),
      .dn_valid_o (stage_valid[k+1]),
      .dn_data_o  (stage_data[k+1]),
      .dn_ready_i (stage_ready[k+1])
    );
  end

  hgp_tail u_tail (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (colour_q),
    .up_valid_i (stage_valid[hgp_pkg::DIV_STEPS]),
    .up_data_i  (stage_data[hgp_pkg::DIV_STEPS]),
    .up_ready_o (stage_ready[hgp_pkg::DIV_STEPS]),
    .out_ch     (out_ch)
  );

endmodule

### src/hgp_checker.sv
// Port-level checks for the gradient palette unit, bound to the top level.
// Depends on hgp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hgp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [hgp_pkg::CH_W-1:0]  hue_i,
  input logic [hgp_pkg::CH_W-1:0]  sat_i,
  input logic [hgp_pkg::CH_W-1:0]  val_i
);

  localparam int unsigned CNT_W = $clog2(hgp_pkg::PIPE_DEPTH + 1);

  logic [CNT_W-1:0] inflight_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken in and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  // A stalled result stays put
  `HGP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i) && $stable(sat_i) && $stable(val_i), "stalled result changed")
  // No result without an item behind it
  `HGP_ASSERT_NEVER(a_no_ghost, out_valid_i && inflight_q == '0, "result with no item in flight")
  // The chain never holds more than its stages
  `HGP_ASSERT_NEVER(a_depth, inflight_q > CNT_W'(hgp_pkg::PIPE_DEPTH), "more items than stages")
  // A full chain with a stalled receiver refuses input
  `HGP_ASSERT(a_full_stall, inflight_q == CNT_W'(hgp_pkg::PIPE_DEPTH) && !out_ready_i |-> !in_ready_i, "full chain accepted an item")

endmodule

bind hsv_gradient_palette_entry_unit hgp_checker u_hgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .hue_i       (out_ch.hue),
  .sat_i       (out_ch.sat),
  .val_i       (out_ch.val)
);

### tb/sv/hsv_gradient_palette_entry_unit_check.sv
// Colour checker for the HSV gradient palette unit: follows the write port,
// works out each palette entry and compares it with what out_ch delivers.
// Depends on hgp_pkg, hgp_in_if and hgp_out_if.
`timescale 1ns / 1ps

module hsv_gradient_palette_entry_unit_check
  import hgp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hgp_in_if                     in_ch,
  hgp_out_if                    out_ch,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int HUE_HALF_TURN = 128;
  localparam int HUE_FULL_TURN = 256;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;
  } hsv_t;

  // Local copy of the registers
  logic [CNT_W-1:0] entry_count;
  colour_cfg_t      colours;

  // Colours still owed by the block, oldest first
  hsv_t        colour_q[$];
  int unsigned reported;

  // One channel: bg + (fg - bg) * pos / span, signed, truncating toward zero
  function automatic logic [CH_W-1:0] blend(input int fg, input int bg, input int pos,
                                            input int span);
    int v;
    v = bg;
    if (span > 0) v = (fg - bg) * pos / span + bg;
    return v[CH_W-1:0];
  endfunction

  function automatic hsv_t palette_entry(input logic [IDX_W-1:0] idx);
    int   count;
    int   span;
    int   pos;
    int   hue_fg;
    int   hue_bg;
    hsv_t c;
    count = int'(entry_count);
    // zero count acts as one entry, oversize count saturates
    if (count < 1) count = 1;
    if (count > int'(MAX_ENTRIES)) count = int'(MAX_ENTRIES);
    span = count - 1;
    pos  = int'(idx);
    if (pos > span) pos = span;
    // hue goes the shorter way round
    hue_fg = int'(colours.fg_hue);
    hue_bg = int'(colours.bg_hue);
    if (hue_fg - hue_bg >= HUE_HALF_TURN) hue_bg += HUE_FULL_TURN;
    else if (hue_fg - hue_bg <= -HUE_HALF_TURN) hue_bg -= HUE_FULL_TURN;
    c.hue = blend(hue_fg, hue_bg, pos, span);
    c.sat = blend(int'(colours.fg_sat), int'(colours.bg_sat), pos, span);
    c.val = blend(int'(colours.fg_val), int'(colours.bg_val), pos, span);
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hsv_t exp_c;
    hsv_t got_c;
    if (!rst_ni) begin
      entry_count  = ENTRY_COUNT_RST;
      colours      = '{fg_hue: FG_HUE_RST, fg_sat: FG_SAT_RST, fg_val: FG_VAL_RST,
                       bg_hue: BG_HUE_RST, bg_sat: BG_SAT_RST, bg_val: BG_VAL_RST};
      colour_q.delete();
      reported     = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // index item accepted: record the colour it must give
      if (in_ch.valid && in_ch.ready) colour_q.push_back(palette_entry(in_ch.entry_index));

      // colour item accepted: compare with the oldest one owed
      if (out_ch.valid && out_ch.ready) begin
        got_c = '{hue: out_ch.hue, sat: out_ch.sat, val: out_ch.val};
        if (colour_q.size() == 0) begin
          fail_count_o++;
          if (reported < REPORT_LIMIT)
            $display("%0t: colour item with none owed: h=%0d s=%0d v=%0d",
                     $time, got_c.hue, got_c.sat, got_c.val);
          reported++;
        end else begin
          exp_c = colour_q.pop_front();
          if (exp_c.hue !== got_c.hue || exp_c.sat !== got_c.sat ||
              exp_c.val !== got_c.val) begin
            fail_count_o++;
            if (reported < REPORT_LIMIT)
              $display("%0t: colour mismatch: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                       $time, exp_c.hue, exp_c.sat, exp_c.val,
                       got_c.hue, got_c.sat, got_c.val);
            reported++;
          end
        end
      end
      pending_o = colour_q.size();

      // register writes; a spare index falls through and is ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENTRY_COUNT: entry_count    = cfg_data_i;
          REG_FG_HUE:      colours.fg_hue = cfg_data_i[CH_W-1:0];
          REG_FG_SAT:      colours.fg_sat = cfg_data_i[CH_W-1:0];
          REG_FG_VAL:      colours.fg_val = cfg_data_i[CH_W-1:0];
          REG_BG_HUE:      colours.bg_hue = cfg_data_i[CH_W-1:0];
          REG_BG_SAT:      colours.bg_sat = cfg_data_i[CH_W-1:0];
          REG_BG_VAL:      colours.bg_val = cfg_data_i[CH_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/hsv_gradient_palette_entry_unit_test.sv
// Top of the HSV gradient palette unit testbench: clock, reset, register set-up,
// paced index items and a stalling receiver; the colour checker gives the verdict data.
// Depends on hgp_pkg, hgp_in_if, hgp_out_if, hsv_gradient_palette_entry_unit(_check).
`timescale 1ns / 1ps

module hsv_gradient_palette_entry_unit_test;
  import hgp_pkg::*;

  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned PRESSURE_ITEMS  = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES   = PIPE_DEPTH + 6;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           fail_count;
  int unsigned           pending;

  rx_mode_e              rx_mode;
  logic                  hold_off_req;
  int unsigned           burst_left;
  int unsigned           gap_max;
  logic [IDX_W-1:0]      idx_list[$];

  hgp_in_if  in_ch();
  hgp_out_if out_ch();

  hsv_gradient_palette_entry_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  hsv_gradient_palette_entry_unit_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: stall pattern per mode, or a long hold-off on request
  initial begin : receiver
    int unsigned held;
    int unsigned tick;
    logic [15:0] rx_pattern;
    out_ch.ready = 1'b0;
    rx_pattern   = 16'h0001;
    tick         = 0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 16 == 0) rx_pattern = 16'($urandom) | 16'h0001;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        held = 1;
        while (held < HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
      end else begin
        case (rx_mode)
          RX_OPEN:    out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            out_ch.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("hsv_gradient_palette_entry_unit_test: done, errors");
    $finish;
  end

  // Offer one index item and hold it until taken; returns on a falling edge
  task automatic send_index(input logic [IDX_W-1:0] idx);
    in_ch.valid       <= 1'b1;
    in_ch.entry_index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Send in bursts with random gaps after each burst
  task automatic send_paced(input logic [IDX_W-1:0] idx);
    int unsigned gap;
    send_index(idx);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_list();
    foreach (idx_list[i]) send_paced(idx_list[i]);
  endtask

  // Stop offering and wait for every owed colour
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Reprogram the whole palette once the block is empty; a spare write goes in too
  task automatic load_palette(input logic [CNT_W-1:0] count,
                              input logic [CH_W-1:0] fh, input logic [CH_W-1:0] fs,
                              input logic [CH_W-1:0] fv, input logic [CH_W-1:0] bh,
                              input logic [CH_W-1:0] bs, input logic [CH_W-1:0] bv);
    drain();
    put_reg(REG_ENTRY_COUNT, count);
    put_reg(REG_FG_HUE, CFG_DATA_W'(fh));
    put_reg(REG_FG_SAT, CFG_DATA_W'(fs));
    put_reg(REG_SPARE, CFG_DATA_W'($urandom));
    put_reg(REG_FG_VAL, CFG_DATA_W'(fv));
    put_reg(REG_BG_HUE, CFG_DATA_W'(bh));
    put_reg(REG_BG_SAT, CFG_DATA_W'(bs));
    put_reg(REG_BG_VAL, CFG_DATA_W'(bv));
    cfg_we_i <= 1'b0;
  endtask

  // Ends of the range now and then, otherwise anywhere
  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // Mostly inside the palette, with the ends and clamped indices mixed in
  function automatic logic [IDX_W-1:0] next_index(input int unsigned span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return IDX_W'($urandom);
      default: return IDX_W'($urandom_range(0, span));
    endcase
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] count;
    logic [CH_W-1:0]  fh, fs, fv, bh, bs, bv;
    int unsigned      span;
    int unsigned      first;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.entry_index = '0;
    hold_off_req      = 1'b0;
    rx_mode           = RX_RANDOM;
    gap_max           = 3;
    burst_left        = 5;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset palette: 16 entries, black to white
    idx_list = '{8'd0, 8'd8, 8'd15, 8'd16, 8'd255};
    send_list();
    // Single entry gives the background
    load_palette(9'd1, 8'd255, 8'd255, 8'd255, 8'd17, 8'd34, 8'd51);
    idx_list = '{8'd0, 8'd255};
    send_list();
    // Zero count acts as a single entry
    load_palette(9'd0, 8'd200, 8'd100, 8'd50, 8'd1, 8'd2, 8'd3);
    idx_list = '{8'd0, 8'd170};
    send_list();
    // Count past the limit saturates; hue gap of exactly +128
    load_palette(9'd511, 8'd200, 8'd0, 8'd255, 8'd72, 8'd255, 8'd0);
    idx_list = '{8'd0, 8'd1, 8'd128, 8'd255};
    send_list();
    // Full palette; hue gap of exactly -128
    load_palette(9'd256, 8'd72, 8'd255, 8'd0, 8'd200, 8'd0, 8'd255);
    idx_list = '{8'd85, 8'd170};
    send_list();
    // Two entries, hue gap +127 stays direct, index past the end clamps
    load_palette(9'd2, 8'd200, 8'd128, 8'd127, 8'd73, 8'd127, 8'd128);
    idx_list = '{8'd0, 8'd1, 8'd2};
    send_list();
    // Three entries, hue crosses zero
    load_palette(9'd3, 8'd5, 8'd10, 8'd20, 8'd250, 8'd240, 8'd230);
    idx_list = '{8'd0, 8'd1, 8'd2, 8'd3};
    send_list();

    // Random palettes, each run with its own pacing
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       count = 9'd0;
        1:       count = 9'd1;
        2:       count = 9'd2;
        3:       count = CNT_W'(MAX_ENTRIES);
        4:       count = CNT_W'($urandom_range(MAX_ENTRIES + 1, 511));
        default: count = CNT_W'($urandom_range(3, MAX_ENTRIES - 1));
      endcase
      fh = rand_channel();
      fs = rand_channel();
      fv = rand_channel();
      bh = rand_channel();
      bs = rand_channel();
      bv = rand_channel();
      // hue gaps around half a turn
      if ($urandom_range(0, 3) == 0) bh = fh + CH_W'($urandom_range(127, 129));
      load_palette(count, fh, fs, fv, bh, bs, bv);

      if (count == 0) span = 0;
      else if (count >= MAX_ENTRIES) span = MAX_ENTRIES - 1;
      else span = count - 1;
      gap_max    = (p % 4 == 0) ? 0 : $urandom_range(1, 8);
      rx_mode    = (p % 4 == 0) ? RX_OPEN : rx_mode_e'($urandom_range(0, 3));
      burst_left = $urandom_range(1, 24);
      first      = 0;

      // Receiver holds off while items keep coming, so the block backs up
      if (p == 2) begin
        rx_mode      = RX_OPEN;
        hold_off_req = 1'b1;
        for (first = 0; first < PRESSURE_ITEMS; first++) send_index(next_index(span));
      end

      for (int k = first; k < PHASE_ITEMS; k++) begin
        // sender waits mid-run until every colour is back
        if (p == 5 && k == PHASE_ITEMS / 2) drain();
        send_paced(next_index(span));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("hsv_gradient_palette_entry_unit_test: done, clean");
    end else begin
      $display("hsv_gradient_palette_entry_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### hsv_gradient_palette_entry_unit.f
+incdir+src
src/hgp_pkg.sv
src/hgp_in_if.sv
src/hgp_out_if.sv
src/hgp_front.sv
src/hgp_div_cell.sv
src/hgp_tail.sv
src/hsv_gradient_palette_entry_unit.sv
src/hgp_checker.sv
tb/sv/hsv_gradient_palette_entry_unit_check.sv
tb/sv/hsv_gradient_palette_entry_unit_test.sv
